FILE: hdl/pbrd_pkg.sv
// Shared constants, types and register map for the pulse beat rate detector.
// No dependencies; used by pbrd_div and pulse_beat_rate_detector.
`default_nettype none

package pbrd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int CFG_BITS    = 16;
  localparam int DIV_BITS    = 16;
  localparam int CNT_BITS    = $clog2(DIV_BITS);
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 5;
  localparam int IDX_BITS    = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [CFG_BITS-1:0]    cfg_t;
  typedef logic [DIV_BITS-1:0]    div_t;
  typedef logic [DATA_BITS-1:0]   data_t;
  typedef logic [IDX_BITS-1:0]    reg_idx_t;

  // Beats per minute numerator (ms per minute)
  localparam div_t RATE_NUM = div_t'(60000);

  // Register indexes
  localparam reg_idx_t REG_TRIGGER  = 3'd0;
  localparam reg_idx_t REG_RELEASE  = 3'd1;
  localparam reg_idx_t REG_MIN_INT  = 3'd2;
  localparam reg_idx_t REG_MAX_INT  = 3'd3;
  localparam reg_idx_t REG_LOW_RATE = 3'd4;
  localparam reg_idx_t REG_HIGH_RATE = 3'd5;

  // Register reset values
  localparam cfg_t RST_TRIGGER   = cfg_t'(35000);
  localparam cfg_t RST_RELEASE   = cfg_t'(2000);
  localparam cfg_t RST_MIN_INT   = cfg_t'(300);
  localparam cfg_t RST_MAX_INT   = cfg_t'(2000);
  localparam cfg_t RST_LOW_RATE  = cfg_t'(30);
  localparam cfg_t RST_HIGH_RATE = cfg_t'(200);

endpackage

`default_nettype wire

FILE: hdl/pbrd_div.sv
// Bit-serial restoring divider: RATE_NUM / divisor, one quotient bit per cycle.
// Depends on pbrd_pkg.
`default_nettype none

module pbrd_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire pbrd_pkg::div_t divisor,
  output logic               done,
  output pbrd_pkg::div_t     quotient
);

  logic                            busy;
  logic [pbrd_pkg::CNT_BITS-1:0]   cnt;
  pbrd_pkg::div_t                  rem;
  pbrd_pkg::div_t                  quo;
  pbrd_pkg::div_t                  dvs;
  logic [pbrd_pkg::DIV_BITS:0]     rem_sh;
  logic [pbrd_pkg::DIV_BITS:0]     diff;
  logic                            ge;
  pbrd_pkg::div_t                  rem_next;
  pbrd_pkg::div_t                  quo_next;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem, quo[pbrd_pkg::DIV_BITS-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = !diff[pbrd_pkg::DIV_BITS];
    rem_next = ge ? diff[pbrd_pkg::DIV_BITS-1:0] : rem_sh[pbrd_pkg::DIV_BITS-1:0];
    quo_next = {quo[pbrd_pkg::DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pbrd_pkg::CNT_BITS'(pbrd_pkg::DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= pbrd_pkg::RATE_NUM;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: hdl/pulse_beat_rate_detector.sv
// Pulse beat rate detector top level: config registers, beat tracking, result register.
// Depends on pbrd_pkg and pbrd_div.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat: a sensor sample and its
//   millisecond timestamp. Output channel (out_valid/out_stall) carries one
//   result beat per input: held rate, in-beat flag, beat-start pulse and the
//   plausibility flag for the rate.
//   Flow: an item that needs no rate update goes straight to the done state; when
//   a new interval falls inside the window the serial divider first works out the
//   rate (one quotient bit per cycle for 16 bits) and its quotient is captured into
//   the held rate. The result is registered into the output register once it is
//   free. One item is worked on at a time.
//   in_stall is high while an item is being worked on or its result is waiting
//   for a free output register. A stalled output holds its result; the block
//   still takes a new item while that result waits.
//   Reset (rst, synchronous) loads register defaults, clears the beat state,
//   last-beat time and held rate, and empties the output register.
//   The APB port writes registers at byte address 4*index; write it only while
//   the block is idle.
`default_nettype none

module pulse_beat_rate_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pbrd_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [pbrd_pkg::DATA_BITS-1:0]    pwdata,
  output logic      [pbrd_pkg::DATA_BITS-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [15:0]                       sample,
  input  wire logic [31:0]                       now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [15:0]                            beats_per_minute,
  output logic                                   in_beat,
  output logic                                   beat_seen,
  output logic                                   rate_plausible
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  pbrd_pkg::cfg_t trigger_level;
  pbrd_pkg::cfg_t release_margin;
  pbrd_pkg::cfg_t min_interval_ms;
  pbrd_pkg::cfg_t max_interval_ms;
  pbrd_pkg::cfg_t low_rate_bound;
  pbrd_pkg::cfg_t high_rate_bound;

  logic [1:0]         state;
  logic               beat_flag;
  pbrd_pkg::time_t    last_beat_ms;
  pbrd_pkg::div_t     rate_hold;
  logic               started;

  pbrd_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;
  logic               accept;
  pbrd_pkg::cfg_t     s_ext;
  pbrd_pkg::time_t    now_t;
  pbrd_pkg::time_t    interval;
  logic               beat_start;
  logic               rate_update;
  logic               release_hit;
  logic               div_done;
  pbrd_pkg::div_t     div_quo;
  logic               out_free;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[pbrd_pkg::ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level   <= pbrd_pkg::RST_TRIGGER;
      release_margin  <= pbrd_pkg::RST_RELEASE;
      min_interval_ms <= pbrd_pkg::RST_MIN_INT;
      max_interval_ms <= pbrd_pkg::RST_MAX_INT;
      low_rate_bound  <= pbrd_pkg::RST_LOW_RATE;
      high_rate_bound <= pbrd_pkg::RST_HIGH_RATE;
    end else if (cfg_wr) begin
      case (reg_idx)
        pbrd_pkg::REG_TRIGGER:   trigger_level   <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        pbrd_pkg::REG_RELEASE:   release_margin  <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        pbrd_pkg::REG_MIN_INT:   min_interval_ms <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        pbrd_pkg::REG_MAX_INT:   max_interval_ms <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        pbrd_pkg::REG_LOW_RATE:  low_rate_bound  <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        pbrd_pkg::REG_HIGH_RATE: high_rate_bound <= pwdata[pbrd_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pbrd_pkg::REG_TRIGGER:   prdata = pbrd_pkg::data_t'(trigger_level);
      pbrd_pkg::REG_RELEASE:   prdata = pbrd_pkg::data_t'(release_margin);
      pbrd_pkg::REG_MIN_INT:   prdata = pbrd_pkg::data_t'(min_interval_ms);
      pbrd_pkg::REG_MAX_INT:   prdata = pbrd_pkg::data_t'(max_interval_ms);
      pbrd_pkg::REG_LOW_RATE:  prdata = pbrd_pkg::data_t'(low_rate_bound);
      pbrd_pkg::REG_HIGH_RATE: prdata = pbrd_pkg::data_t'(high_rate_bound);
      default:                 prdata = '0;
    endcase
  end

  // Beat detection on the incoming beat
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s_ext       = pbrd_pkg::cfg_t'(sample[pbrd_pkg::SAMPLE_BITS-1:0]);
    now_t       = now_ms[pbrd_pkg::TIME_BITS-1:0];
    interval    = now_t - last_beat_ms;
    beat_start  = (s_ext > trigger_level) && !beat_flag;
    rate_update = beat_start
               && (interval > pbrd_pkg::time_t'(min_interval_ms))
               && (interval < pbrd_pkg::time_t'(max_interval_ms));
    // A margin above the trigger level means the beat never releases
    release_hit = (release_margin <= trigger_level)
               && (s_ext < (trigger_level - release_margin));
  end

  pbrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && rate_update),
    .divisor  (interval[pbrd_pkg::DIV_BITS-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      beat_flag    <= 1'b0;
      last_beat_ms <= '0;
      rate_hold    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            beat_flag <= (beat_start || beat_flag) && !release_hit;
            if (beat_start) begin
              last_beat_ms <= now_t;
            end
            state <= rate_update ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            rate_hold <= div_quo;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      started <= beat_start;
    end
    if ((state == ST_DONE) && out_free) begin
      beats_per_minute <= rate_hold;
      in_beat          <= beat_flag;
      beat_seen        <= started;
      rate_plausible   <= (rate_hold > low_rate_bound) && (rate_hold < high_rate_bound);
    end
  end

  a_seen_in_beat : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!beat_seen || in_beat))
    else $error("beat start reported without in-beat flag");

  a_div_only_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_quo_bound : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quo <= pbrd_pkg::RATE_NUM))
    else $error("rate quotient above numerator");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after accepting a beat");

endmodule

`default_nettype wire
